@@ hw/rtl/bmhq_pkg.sv @@
// Shared types, codes and sizes for the binary min-heap queue unit.
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int WORD_W       = 32;
  localparam int COUNT_W      = 7;
  localparam int OPCODE_W     = 2;
  localparam int STATUS_W     = 2;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_REM_EMPTY = 2'd1,
    STATUS_INS_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell of the row for one beat.
  typedef struct packed {
    logic  ins;
    logic  rem;
    word_t value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/binary_min_heap_queue_unit.sv @@
// Top level of the min priority queue: cell row, beat decode and result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | input     | in_valid / in_ready  | opcode, value
//   out     | output    | out_valid / out_ready| min_value, count, is_empty, status
//
// Each input beat is applied to the cell row in the cycle it is accepted, and its
// result beat is presented from the output register on the following cycle.
// The row compares all cells in parallel.
// in_ready is high whenever the result register is empty or being drained.
// Reset clears the element count and the output valid; the cell contents are
// left as they are and are only read below the element count.
`default_nettype none

module binary_min_heap_queue_unit #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [bmhq_pkg::OPCODE_W-1:0]         opcode,
  input  bmhq_pkg::word_t                       value,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output bmhq_pkg::word_t                       min_value,
  output logic [bmhq_pkg::COUNT_W-1:0]          count,
  output logic                                  is_empty,
  output logic [bmhq_pkg::STATUS_W-1:0]         status
);
  import bmhq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // The queue is held as an ascending row of cells: cell 0 is always the
  // minimum. An insert opens a gap at the first cell greater than the new
  // value and shifts the tail right by one; a remove shifts the whole row left.
  // This returns the same minimum and count as a heap for every sequence.

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             accept;
  logic             do_ins;
  logic             do_rem;
  status_t          st;
  cell_ctrl_t       ctrl;

  word_t            cell_data [CAPACITY];
  word_t            cell_next [CAPACITY];
  logic             cell_le   [CAPACITY];
  logic             cell_valid[CAPACITY];

  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Decode the opcode against the current fill level. An unused opcode acts
  // as a plain query.
  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    st       = STATUS_OK;
    cnt_next = cnt;
    unique case (opcode_t'(opcode))
      OP_INSERT: begin
        if (cnt == CNT_W'(CAPACITY)) begin
          st = STATUS_INS_FULL;
        end else begin
          do_ins   = 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (cnt == '0) begin
          st = STATUS_REM_EMPTY;
        end else begin
          do_rem   = 1'b1;
          cnt_next = cnt - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctrl.ins   = accept && do_ins;
  assign ctrl.rem   = accept && do_rem;
  assign ctrl.value = value;

  // The row of cells. Each cell sees its two neighbors' values and the
  // left neighbor's compare result; the end cells see their own value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_d;
    word_t right_d;
    logic  le_in;

    assign cell_valid[i] = (CNT_W'(i) < cnt);

    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
      assign le_in  = 1'b1;
    end else begin : g_inner_l
      assign left_d = cell_data[i-1];
      assign le_in  = cell_le[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner_r
      assign right_d = cell_data[i+1];
    end

    bmhq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (cell_valid[i]),
      .le_prev    (le_in),
      .left_data  (left_d),
      .right_data (right_d),
      .le         (cell_le[i]),
      .data       (cell_data[i]),
      .data_next  (cell_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  // The count field carries the low bits of the element count.
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_next};

  // Result register: it holds one finished beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      min_value <= (cnt_next == '0) ? word_t'(0) : cell_next[0];
      count     <= cnt_ext[COUNT_W-1:0];
      is_empty  <= (cnt_next == '0);
      status    <= st;
    end
  end

  // The element count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  // The two lowest occupied cells are in ascending order.
  a_row_sorted: assert property (@(posedge clk) disable iff (rst)
    (cnt >= CNT_W'(2)) |-> (cell_data[0] <= cell_data[1]))
    else $error("cell row out of order");

  // A remove on an empty queue is flagged and leaves the queue empty.
  a_rem_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_REMOVE && cnt == '0)
      |=> (out_valid && status == STATUS_REM_EMPTY && is_empty && cnt == '0))
    else $error("remove on empty not flagged");

  // An insert below capacity grows the count by exactly one.
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_INSERT && cnt != CNT_W'(CAPACITY))
      |=> (cnt == $past(cnt) + 1'b1))
    else $error("insert did not grow the count");

endmodule

`default_nettype wire

@@ hw/rtl/bmhq_cell.sv @@
// One slot of the sorted cell row: holds a value and shifts it left or right.
`default_nettype none

module bmhq_cell (
  input  wire                   clk,
  input  bmhq_pkg::cell_ctrl_t  ctrl,
  input  wire                   valid,
  input  wire                   le_prev,
  input  bmhq_pkg::word_t       left_data,
  input  bmhq_pkg::word_t       right_data,
  output logic                  le,
  output bmhq_pkg::word_t       data,
  output bmhq_pkg::word_t       data_next
);
  import bmhq_pkg::*;

  // Values are kept in ascending order, so le is high for a prefix of the row.
  assign le = valid && (data <= ctrl.value);

  always_comb begin
    data_next = data;
    if (ctrl.rem) begin
      data_next = right_data;
    end else if (ctrl.ins) begin
      if (le) begin
        data_next = data;
      end else if (le_prev) begin
        data_next = ctrl.value;
      end else begin
        data_next = left_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins || ctrl.rem) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/heap_queue_watch.sv @@
// Watches both channels of the heap queue, keeps a shadow heap and checks each result beat.
`timescale 1ns / 100ps

module heap_queue_watch #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  input  wire                           in_ready,
  input  wire  [bmhq_pkg::OPCODE_W-1:0] opcode,
  input  bmhq_pkg::word_t               value,
  input  wire                           out_valid,
  input  wire                           out_ready,
  input  bmhq_pkg::word_t               min_value,
  input  wire  [bmhq_pkg::COUNT_W-1:0]  count,
  input  wire                           is_empty,
  input  wire  [bmhq_pkg::STATUS_W-1:0] status,
  output int                            errors,
  output int                            pending
);
  import bmhq_pkg::*;

  typedef struct packed {
    word_t                min_value;
    logic [COUNT_W-1:0]   count;
    logic                 is_empty;
    status_t              status;
  } queue_view_t;

  // Shadow copy of the heap array and its fill level.
  word_t       heap_slots [CAPACITY];
  int          stored = 0;
  queue_view_t queue_views_due [$];
  int          mismatch_total = 0;
  int          views_waiting = 0;

  assign errors  = mismatch_total;
  assign pending = views_waiting;

  // Applies one operation to the shadow heap and returns the view of the queue after it.
  function automatic queue_view_t apply_op(input logic [OPCODE_W-1:0] op, input word_t v);
    queue_view_t view;
    int          node;
    int          parent;
    int          left;
    int          pick;
    word_t       held;
    view.status = STATUS_OK;
    if (op == OP_INSERT) begin
      if (stored >= CAPACITY) begin
        view.status = STATUS_INS_FULL;
      end else begin
        node = stored;
        heap_slots[node] = v;
        stored++;
        // Sift up; a parent that is not greater stops the walk.
        while (node > 0) begin
          parent = (node - 1) / 2;
          if (!(heap_slots[node] < heap_slots[parent])) break;
          held               = heap_slots[parent];
          heap_slots[parent] = heap_slots[node];
          heap_slots[node]   = held;
          node               = parent;
        end
      end
    end else if (op == OP_REMOVE) begin
      if (stored == 0) begin
        view.status = STATUS_REM_EMPTY;
      end else begin
        stored--;
        heap_slots[0] = heap_slots[stored];
        node = 0;
        // Sift down; the right child wins only when strictly smaller than the left.
        while (1) begin
          left = 2 * node + 1;
          if (left >= stored) break;
          pick = left;
          if (left + 1 < stored && heap_slots[left + 1] < heap_slots[left]) pick = left + 1;
          if (!(heap_slots[pick] < heap_slots[node])) break;
          held             = heap_slots[pick];
          heap_slots[pick] = heap_slots[node];
          heap_slots[node] = held;
          node             = pick;
        end
      end
    end
    view.min_value = (stored == 0) ? '0 : heap_slots[0];
    view.count     = COUNT_W'(stored);
    view.is_empty  = (stored == 0);
    return view;
  endfunction

  always @(posedge clk) begin
    queue_view_t want;
    if (rst) begin
      stored = 0;
      queue_views_due.delete();
    end else begin
      // The result beat leaving now always belongs to an older item than the one entering.
      if (out_valid && out_ready) begin
        if (queue_views_due.size() == 0) begin
          $error("result beat arrived with no item waiting for it");
          mismatch_total++;
        end else begin
          want = queue_views_due.pop_front();
          if (min_value !== want.min_value) begin
            $error("min_value: expected %0d, got %0d", want.min_value, min_value);
            mismatch_total++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            mismatch_total++;
          end
          if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
            mismatch_total++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatch_total++;
          end
        end
      end
      if (in_valid && in_ready) begin
        queue_views_due = {queue_views_due, apply_op(opcode, value)};
      end
    end
    views_waiting = queue_views_due.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the heap queue testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
  import bmhq_pkg::*;

  // Opcode three has no name in the package; the block treats it as a query.
  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
  // Cycles without any beat on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1880;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  wire                  in_ready;
  logic [OPCODE_W-1:0]  opcode = '0;
  word_t                value = '0;
  wire                  out_valid;
  logic                 out_ready = 1'b0;
  word_t                min_value;
  wire  [COUNT_W-1:0]   count;
  wire                  is_empty;
  wire  [STATUS_W-1:0]  status;

  int errors;
  int pending;
  int quiet_cycles = 0;
  // When clear, neither side inserts bubbles, so beats run back to back.
  bit gaps_enabled = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_min_heap_queue_unit #(
    .CAPACITY (CAPACITY_DEF)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_value (min_value),
    .count     (count),
    .is_empty  (is_empty),
    .status    (status)
  );

  heap_queue_watch #(
    .CAPACITY (CAPACITY_DEF)
  ) watch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_value (min_value),
    .count     (count),
    .is_empty  (is_empty),
    .status    (status),
    .errors    (errors),
    .pending   (pending)
  );

  // The receiver stalls with a chance of about six percent while gaps are enabled.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !gaps_enabled || ($urandom_range(99) >= 6);
    end
  end

  // Any cycle that moves a beat on either channel restarts the hang counter.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Presents one item and holds it until the block takes it. Valid is left high on return,
  // so the next call either replaces the payload or drops valid for a bubble, never both
  // in the same step.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input word_t v);
    @(negedge clk);
    while (gaps_enabled && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int          sent;
    int          burst_left;
    int          mode;
    int          pick;
    logic [OPCODE_W-1:0] op;
    word_t       v;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty queue corners, both ends of the value range, the reserved
    // opcode, and runs of equal keys pushed through both sift directions.
    send_item(OP_QUERY, 32'sd0);
    send_item(OP_REMOVE, 32'sd0);
    send_item(OP_RESERVED, -32'sd1);
    send_item(OP_INSERT, 32'sh7fffffff);
    send_item(OP_INSERT, 32'sh80000000);
    send_item(OP_QUERY, 32'sh12345678);
    send_item(OP_INSERT, 32'sd0);
    send_item(OP_INSERT, -32'sd1);
    send_item(OP_INSERT, 32'sd5);
    send_item(OP_INSERT, 32'sd5);
    send_item(OP_INSERT, 32'sd5);
    send_item(OP_RESERVED, 32'sh5a5a5a5a);
    repeat (7) send_item(OP_REMOVE, 32'sd0);
    send_item(OP_REMOVE, 32'sd0);
    send_item(OP_INSERT, 32'sd3);
    send_item(OP_INSERT, 32'sd1);
    send_item(OP_INSERT, 32'sd2);
    send_item(OP_REMOVE, 32'sd0);

    // Random part, in bursts. The first burst only inserts, so the queue fills and then
    // overflows early. Later bursts lean toward filling, draining or a balanced mix, which
    // walks the count between empty and full again and again.
    sent       = 0;
    burst_left = 0;
    mode       = 3;
    while (sent < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left = (mode == 3 && sent == 0) ? 70 : $urandom_range(20, 130);
        if (sent != 0) mode = $urandom_range(2);
      end
      // A stretch in the middle of the run has no bubbles on either side.
      gaps_enabled = !(sent >= 700 && sent < 1000);

      pick = $urandom_range(99);
      case (mode)
        0: begin
          op = (pick < 75) ? OP_INSERT : (pick < 90) ? OP_REMOVE :
               (pick < 97) ? OP_QUERY : OP_RESERVED;
        end
        1: begin
          op = (pick < 15) ? OP_INSERT : (pick < 90) ? OP_REMOVE :
               (pick < 97) ? OP_QUERY : OP_RESERVED;
        end
        2: begin
          op = (pick < 45) ? OP_INSERT : (pick < 90) ? OP_REMOVE :
               (pick < 97) ? OP_QUERY : OP_RESERVED;
        end
        default: begin
          op = OP_INSERT;
        end
      endcase

      // Mostly full-range values; a share of small values to force equal keys, and a few
      // taken straight from the extremes.
      pick = $urandom_range(9);
      if (pick < 5) begin
        v = word_t'($urandom);
      end else if (pick < 8) begin
        v = word_t'($urandom_range(15)) - 32'sd8;
      end else begin
        case ($urandom_range(3))
          0:       v = 32'sh7fffffff;
          1:       v = 32'sh80000000;
          2:       v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end

      send_item(op, v);
      sent++;
      burst_left--;
    end

    gaps_enabled = 1'b1;
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: every expected result must come back, then a short settle for strays.
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ binary_min_heap_queue_unit.f @@
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_cell.sv
hw/rtl/binary_min_heap_queue_unit.sv
tb/sv/heap_queue_watch.sv
tb/sv/testbench.sv
